### rtl/drrip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_pkg
// shared sizes, row layout and helper functions of the dead-block drrip
// replacement engine
// ----------------------------------------------------------------------------
package drrip_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int NUM_WAYS       = 16;
    localparam int LEADER_SETS    = 64;
    localparam int SELECTOR_WIDTH = 10;
    localparam int DECAY_PERIOD   = 4096;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int ACC_W = $clog2(DECAY_PERIOD);
    localparam int SEL_W = SELECTOR_WIDTH;

    // beat field widths
    localparam int SET_FIELD_W = 11;
    localparam int WAY_FIELD_W = 4;
    localparam int VIC_FIELD_W = 4;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [1:0] REREF_MAX = 2'd3;
    localparam logic [1:0] DEAD_SAT  = 2'd3;
    localparam logic [1:0] INS_NEAR  = 2'd2;
    localparam logic [1:0] INS_FAR   = 2'd3;

    localparam logic [SEL_W-1:0] SEL_MAX  = SEL_W'((1 << SELECTOR_WIDTH) - 1);
    localparam logic [SEL_W-1:0] SEL_HALF = SEL_W'(((1 << SELECTOR_WIDTH) - 1) / 2);

    localparam logic [ACC_W-1:0] ACC_LAST     = ACC_W'(DECAY_PERIOD - 1);
    localparam logic [ACC_W-1:0] BIMODAL_MASK = ACC_W'(32'h1F);

    localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

    typedef logic [NUM_WAYS-1:0][1:0] ctr_vec_t;

    // one cache set per memory row
    typedef struct packed {
        ctr_vec_t dead;
        ctr_vec_t reref;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // per-item control handed to the row modify logic
    typedef struct packed {
        logic             query;
        logic             hit;
        logic             way_ok;
        logic [WAY_W-1:0] way;
        logic [1:0]       ins;
    } upd_ctrl_t;

    function automatic row_t row_init();
        row_t r;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            r.reref[w] = REREF_MAX;
            r.dead[w]  = 2'd0;
        end
        return r;
    endfunction

    function automatic row_t row_decay(input row_t r_in);
        row_t r;
        r = r_in;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (r_in.dead[w] != 2'd0)
                r.dead[w] = r_in.dead[w] - 2'd1;
        end
        return r;
    endfunction

    // lowest set bit, zero when none
    function automatic logic [WAY_W-1:0] first_one(input logic [NUM_WAYS-1:0] v);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (v[w])
                idx = WAY_W'(w);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

### rtl/drrip_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/drrip_row_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_row_update
// modify step of one set row: victim search with aging, or hit / miss update
// ----------------------------------------------------------------------------
module drrip_row_update import drrip_pkg::*; (
    input  row_t             row_in,
    input  upd_ctrl_t        ctrl,
    output row_t             row_out,
    output logic [WAY_W-1:0] victim
);

    logic [NUM_WAYS-1:0] dead_full;
    logic [NUM_WAYS-1:0] reref_full;
    logic [NUM_WAYS-1:0] aged_full;
    ctr_vec_t            aged;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            dead_full[w]  = (row_in.dead[w] == DEAD_SAT);
            reref_full[w] = (row_in.reref[w] == REREF_MAX);
            aged[w]       = reref_full[w] ? REREF_MAX : row_in.reref[w] + 2'd1;
            aged_full[w]  = (aged[w] == REREF_MAX);
        end
    end

    always_comb
    begin
        row_out = row_in;
        victim  = '0;
        if (ctrl.query)
        begin
            if (|dead_full)
                victim = first_one(dead_full);
            else if (|reref_full)
                victim = first_one(reref_full);
            else
            begin
                // age the whole set once, then search again
                row_out.reref = aged;
                victim        = first_one(aged_full);
            end
        end
        else if (ctrl.way_ok)
        begin
            if (ctrl.hit)
            begin
                row_out.reref[ctrl.way] = 2'd0;
                row_out.dead[ctrl.way]  = 2'd0;
            end
            else
            begin
                if (row_in.dead[ctrl.way] != DEAD_SAT)
                    row_out.dead[ctrl.way] = row_in.dead[ctrl.way] + 2'd1;
                row_out.reref[ctrl.way] = ctrl.ins;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/drrip_dead_block_replacement.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_dead_block_replacement
// drrip cache replacement with per-block dead counters
// ----------------------------------------------------------------------------
// One set row (re-reference values and dead counters of all ways) lives in a
// single synchronous ram of NUM_SETS rows. Each beat reads its set row when it
// is accepted; the modify state then changes the row and writes it back, and
// the next beat is taken in the cycle after that write. A query's victim is
// held in an output register; the following beat may be accepted while it
// waits, and only a further query stalls until it is taken. Every
// DECAY_PERIOD-th update first runs a decay sweep over the whole ram (one row
// read per cycle, written back in the next cycle) before that update. After
// reset a clearing pass writes every row once before the first beat is
// accepted.
module drrip_dead_block_replacement import drrip_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // set_index[10:0], way_index[14:11], was_hit[15]
    input  logic                  s_axis_tuser,   // kind[0]
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // victim_way[3:0], zero[7:4]
);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RMW   = 3'd2;
    localparam logic [2:0] ST_DECAY = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [SET_W-1:0]       ptr_reg, ptr_next;
    logic                   rd_done_reg, rd_done_next;
    logic                   wb_pend_reg, wb_pend_next;
    logic [SET_W-1:0]       wb_addr_reg, wb_addr_next;
    logic [SEL_W-1:0]       sel_reg, sel_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VIC_FIELD_W-1:0] out_way_reg, out_way_next;

    // latched beat
    logic                   kind_reg, kind_next;
    logic [SET_W-1:0]       set_reg, set_next;
    logic [WAY_FIELD_W-1:0] way_reg, way_next;
    logic                   hit_reg, hit_next;

    // ram port
    logic                   ram_wr_en;
    logic [SET_W-1:0]       ram_wr_addr;
    row_t                   ram_wr_data;
    logic                   ram_rd_en;
    logic [SET_W-1:0]       ram_rd_addr;
    logic [ROW_W-1:0]       ram_rd_data;
    row_t                   row_rd;

    // beat fields
    logic                   in_kind;
    logic [SET_W-1:0]       in_set;
    logic [WAY_FIELD_W-1:0] in_way;
    logic                   in_hit;

    logic [ACC_W-1:0]       acc_inc;
    logic                   srrip_leader;
    logic                   brrip_leader;
    logic                   rmw_go;
    upd_ctrl_t              ctrl;
    row_t                   row_mod;
    logic [WAY_W-1:0]       victim;

    assign in_kind = s_axis_tuser;
    assign in_set  = SET_W'(s_axis_tdata[SET_FIELD_W-1:0] % NUM_SETS);
    assign in_way  = s_axis_tdata[SET_FIELD_W +: WAY_FIELD_W];
    assign in_hit  = s_axis_tdata[SET_FIELD_W + WAY_FIELD_W];

    assign acc_inc = (acc_reg == ACC_LAST) ? '0 : acc_reg + 1'b1;

    // leader sets are fixed: low half srrip, upper half brrip
    assign srrip_leader = (int'(set_reg) < LEADER_SETS / 2);
    assign brrip_leader = !srrip_leader && (int'(set_reg) < LEADER_SETS);

    assign row_rd = row_t'(ram_rd_data);

    always_comb
    begin
        ctrl.query  = (kind_reg == KIND_QUERY);
        ctrl.hit    = hit_reg;
        ctrl.way_ok = (int'(way_reg) < NUM_WAYS);
        ctrl.way    = WAY_W'(way_reg);
        // insertion value: srrip inserts near, brrip mostly far with a
        // near insert once every 32 updates
        if (srrip_leader || (!brrip_leader && sel_reg >= SEL_HALF))
            ctrl.ins = INS_NEAR;
        else if ((acc_reg & BIMODAL_MASK) == '0)
            ctrl.ins = INS_NEAR;
        else
            ctrl.ins = INS_FAR;
    end

    drrip_row_update u_row_update (
        .row_in  (row_rd),
        .ctrl    (ctrl),
        .row_out (row_mod),
        .victim  (victim)
    );

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // a query can only finish when the output register is free or draining
    assign rmw_go = (kind_reg == KIND_UPDATE) || !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        rd_done_next   = rd_done_reg;
        wb_pend_next   = 1'b0;
        wb_addr_next   = wb_addr_reg;
        sel_next       = sel_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_way_next   = out_way_reg;
        kind_next      = kind_reg;
        set_next       = set_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = ptr_reg;
        ram_wr_data    = row_init();
        ram_rd_en      = 1'b0;
        ram_rd_addr    = in_set;
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // write the reset row into every set
                ram_wr_en = 1'b1;
                if (ptr_reg == SET_LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    kind_next = in_kind;
                    set_next  = in_set;
                    way_next  = in_way;
                    hit_next  = in_hit;
                    ram_rd_en = 1'b1;
                    if (in_kind == KIND_UPDATE)
                    begin
                        acc_next = acc_inc;
                        if (acc_inc == '0)
                        begin
                            // decay period elapsed: sweep before the update
                            ptr_next     = '0;
                            rd_done_next = 1'b0;
                            state_next   = ST_DECAY;
                        end
                        else
                            state_next = ST_RMW;
                    end
                    else
                        state_next = ST_RMW;
                end
            end

            ST_DECAY:
            begin
                // read row n while writing back row n-1
                if (!rd_done_reg)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = ptr_reg;
                    wb_pend_next = 1'b1;
                    wb_addr_next = ptr_reg;
                    if (ptr_reg == SET_LAST)
                        rd_done_next = 1'b1;
                    else
                        ptr_next = ptr_reg + 1'b1;
                end
                if (wb_pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wb_addr_reg;
                    ram_wr_data = row_decay(row_rd);
                end
                if (rd_done_reg && !wb_pend_reg)
                    state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = set_reg;
                state_next  = ST_RMW;
            end

            ST_RMW:
            begin
                if (rmw_go)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = set_reg;
                    ram_wr_data = row_mod;
                    if (kind_reg == KIND_QUERY)
                    begin
                        out_valid_next = 1'b1;
                        out_way_next   = VIC_FIELD_W'(victim);
                    end
                    else if (hit_reg && ctrl.way_ok)
                    begin
                        // set dueling is trained on hits in leader sets
                        if (srrip_leader && sel_reg != SEL_MAX)
                            sel_next = sel_reg + 1'b1;
                        else if (brrip_leader && sel_reg != '0)
                            sel_next = sel_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            rd_done_reg   <= 1'b0;
            wb_pend_reg   <= 1'b0;
            sel_reg       <= SEL_HALF;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_done_reg   <= rd_done_next;
            wb_pend_reg   <= wb_pend_next;
            sel_reg       <= sel_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        wb_addr_reg <= wb_addr_next;
        out_way_reg <= out_way_next;
        kind_reg    <= kind_next;
        set_reg     <= set_next;
        way_reg     <= way_next;
        hit_reg     <= hit_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VIC_FIELD_W){1'b0}}, out_way_reg};

endmodule
`default_nettype wire

### rtl/drrip_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_checker
// port-level checks of the replacement engine, bound to the top level
// ----------------------------------------------------------------------------
module drrip_checker import drrip_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic in_beat;
    logic query_beat;

    assign in_beat    = s_axis_tvalid && s_axis_tready;
    assign query_beat = in_beat && (s_axis_tuser == KIND_QUERY);

    // a stalled result beat holds its victim
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a new result must trace back to an earlier query beat
    a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(query_beat, 2))
        else $error("result without a matching query beat");

    // one beat at a time: ready drops right after a beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("beat accepted while previous beat in flight");

    // updates never produce a result
    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (s_axis_tuser == KIND_UPDATE) |-> ##2 !$rose(m_axis_tvalid))
        else $error("result produced by an update beat");

endmodule

bind drrip_dead_block_replacement drrip_checker u_checker (.*);
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dead-block drrip replacement engine
// ----------------------------------------------------------------------------
// A queue of query and update beats, filled up front, feeds a clocked driver.
// A behavioral copy of the replacement state, advanced on every accepted beat,
// predicts each victim. A clocked monitor compares every victim beat with the
// oldest prediction. Traffic runs through several pacing phases and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import drrip_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RAND_PHASE  = 450;   // random beats per pacing phase
    localparam int HOLD_CYCLES = 400;   // receiver hold-off length
    localparam int DRAIN_WAIT  = 2100;  // quiet time after the last beat
    localparam int LIMIT_CYC   = 700000;

    // pacing of both sides, carried with every beat
    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic                   kind;
        logic [SET_FIELD_W-1:0] set_idx;
        logic [WAY_FIELD_W-1:0] way;
        logic                   hit;
        pace_t                  pace;
    } beat_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // stimulus bookkeeping
    beat_t pending_beats[$];
    beat_t cur_beat;
    pace_t cur_pace   = PACE_FULL;
    logic  hold_rx    = 1'b0;
    int    total_beats;
    int    accepted_cnt = 0;
    int    errors       = 0;

    // predicted replacement state
    logic [1:0]       reuse_dist [NUM_SETS][NUM_WAYS];
    logic [1:0]       dead_cnt   [NUM_SETS][NUM_WAYS];
    logic [SEL_W-1:0] duel_sel;
    logic [ACC_W-1:0] upd_count;
    logic [VIC_FIELD_W-1:0] victim_queue[$];

    // sets that see repeated traffic: both leader kinds, followers, the edges
    int hot_sets[12] = '{0, 1, 31, 32, 33, 63, 64, 100, 700, 1024, 2046, 2047};

    drrip_dead_block_replacement i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // set_index[10:0], way_index[14:11], was_hit[15]
        .s_axis_tuser  (s_axis_tuser),   // kind[0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // victim_way[3:0], zero[7:4]
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor: advances the replacement state by one accepted beat
    // ------------------------------------------------------------------------
    function automatic void predict_beat(input beat_t b);
        int               s;
        int               w;
        logic             found;
        logic [WAY_W-1:0] pick;
        logic             srrip_ldr;
        logic             brrip_ldr;
        s = int'(b.set_idx) % NUM_SETS;
        w = int'(b.way);
        if (b.kind == KIND_QUERY)
        begin
            found = 1'b0;
            pick  = '0;
            // dead block first
            for (int v = 0; v < NUM_WAYS; v++)
                if (!found && dead_cnt[s][v] == DEAD_SAT)
                begin
                    found = 1'b1;
                    pick  = WAY_W'(v);
                end
            // then distant re-reference
            for (int v = 0; v < NUM_WAYS; v++)
                if (!found && reuse_dist[s][v] == REREF_MAX)
                begin
                    found = 1'b1;
                    pick  = WAY_W'(v);
                end
            // age the whole set once and retry, way 0 when still nothing
            if (!found)
            begin
                for (int v = 0; v < NUM_WAYS; v++)
                    if (reuse_dist[s][v] != REREF_MAX)
                        reuse_dist[s][v] = reuse_dist[s][v] + 2'd1;
                for (int v = 0; v < NUM_WAYS; v++)
                    if (!found && reuse_dist[s][v] == REREF_MAX)
                    begin
                        found = 1'b1;
                        pick  = WAY_W'(v);
                    end
            end
            victim_queue.push_back(VIC_FIELD_W'(pick));
        end
        else
        begin
            upd_count = (upd_count == ACC_LAST) ? '0 : upd_count + 1'b1;
            // periodic decay over the whole store
            if (upd_count == '0)
                for (int s2 = 0; s2 < NUM_SETS; s2++)
                    for (int v = 0; v < NUM_WAYS; v++)
                        if (dead_cnt[s2][v] != 2'd0)
                            dead_cnt[s2][v] = dead_cnt[s2][v] - 2'd1;
            srrip_ldr = (s < LEADER_SETS / 2);
            brrip_ldr = !srrip_ldr && (s < LEADER_SETS);
            if (w < NUM_WAYS)
            begin
                if (b.hit)
                begin
                    reuse_dist[s][w] = 2'd0;
                    dead_cnt[s][w]   = 2'd0;
                    // duel training on leader hits, saturating both ways
                    if (srrip_ldr && duel_sel != SEL_MAX)
                        duel_sel = duel_sel + 1'b1;
                    else if (brrip_ldr && duel_sel != '0)
                        duel_sel = duel_sel - 1'b1;
                end
                else
                begin
                    if (dead_cnt[s][w] != DEAD_SAT)
                        dead_cnt[s][w] = dead_cnt[s][w] + 2'd1;
                    if (srrip_ldr || (!brrip_ldr && duel_sel >= SEL_HALF))
                        reuse_dist[s][w] = INS_NEAR;
                    else
                        reuse_dist[s][w] = ((upd_count & BIMODAL_MASK) == '0) ?
                                           INS_NEAR : INS_FAR;
                end
            end
        end
    endfunction

    function automatic void add_beat(input logic kind, input int set_i, input int way_i,
                                     input logic hit, input pace_t pace);
        beat_t b;
        b.kind    = kind;
        b.set_idx = SET_FIELD_W'(set_i);
        b.way     = WAY_FIELD_W'(way_i);
        b.hit     = hit;
        b.pace    = pace;
        pending_beats.push_back(b);
    endfunction

    // half the time a hot set so blocks build up history, else any set
    function automatic int pick_set();
        if ($urandom_range(0, 1) == 0)
            return hot_sets[$urandom_range(0, 11)];
        return int'($urandom_range(0, NUM_SETS - 1));
    endfunction

    // often only ways 0 to 3, so dead counters can saturate
    function automatic int pick_way();
        if ($urandom_range(0, 1) == 0)
            return int'($urandom_range(0, 3));
        return int'($urandom_range(0, NUM_WAYS - 1));
    endfunction

    function automatic int send_idle_pct(input pace_t p);
        case (p)
            PACE_SEND_IDLE: return 74;
            PACE_BOTH:      return 18;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input pace_t p);
        case (p)
            PACE_RECV_STALL: return 74;
            PACE_BOTH:       return 18;
            default:         return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers the next pending beat, predicts on every accepted one
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drv_proc
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_beat(cur_beat);
                accepted_cnt++;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_beats.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(pending_beats[0].pace))
                begin
                    cur_beat = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_beat.hit, cur_beat.way, cur_beat.set_idx};
                    s_axis_tuser  <= cur_beat.kind;
                    cur_pace      <= cur_beat.pace;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each victim beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : mon_proc
        logic [OUT_DATA_W-1:0] want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (victim_queue.size() == 0)
                begin
                    $display("%0t: victim beat with none expected, actual %0d",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    // upper bits of the beat must stay zero
                    want = OUT_DATA_W'(victim_queue.pop_front());
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: victim mismatch, expected %0d, actual %0d",
                                 $time, want, m_axis_tdata);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct(cur_pace));
        end
    end

    // long receiver hold-off while the sender keeps offering beats
    initial
    begin : hold_proc
        int n;
        wait (accepted_cnt >= 60);
        @(posedge clk);
        hold_rx <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #(CLK_HALF * 2 * LIMIT_CYC);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : main_proc
        int    r;
        pace_t pace;
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                reuse_dist[s][w] = REREF_MAX;
                dead_cnt[s][w]   = 2'd0;
            end
        duel_sel  = SEL_HALF;
        upd_count = '0;

        // directed: fresh set, fully promoted set hitting the way-0 fallback,
        // a block driven dead by repeated misses at the top set and way
        add_beat(KIND_QUERY, 0, 0, 1'b0, PACE_FULL);
        for (int w = 0; w < NUM_WAYS; w++)
            add_beat(KIND_UPDATE, 5, w, 1'b1, PACE_FULL);
        add_beat(KIND_QUERY, 5, 0, 1'b0, PACE_FULL);
        add_beat(KIND_QUERY, 5, 15, 1'b1, PACE_FULL);
        for (int n = 0; n < 3; n++)
            add_beat(KIND_UPDATE, NUM_SETS - 1, NUM_WAYS - 1, 1'b0, PACE_FULL);
        add_beat(KIND_QUERY, NUM_SETS - 1, 0, 1'b0, PACE_FULL);
        add_beat(KIND_UPDATE, LEADER_SETS / 2, 7, 1'b1, PACE_FULL);

        // random traffic through every pacing phase
        for (int p = 0; p < 4; p++)
        begin
            pace = pace_t'(p);
            for (int n = 0; n < RAND_PHASE; n++)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 35)
                    add_beat(KIND_QUERY, pick_set(), int'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)), pace);
                else
                    add_beat(KIND_UPDATE, pick_set(), pick_way(), r < 65, pace);
            end
        end
        total_beats = pending_beats.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_cnt == total_beats && victim_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
rtl/drrip_pkg.sv
rtl/drrip_ram.sv
rtl/drrip_row_update.sv
rtl/drrip_dead_block_replacement.sv
rtl/drrip_checker.sv
dv/tb_top.sv
